FILE: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int WORD_W = 32;
	localparam int FILL_W = 9;
	localparam int KIND_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
		logic load;
	} deq_cmd_t;

	typedef struct packed {
		logic out_free;
	} deq_status_t;

endpackage

FILE: hdl/deq_ctrl.sv
// Controller state machine that sequences one deque operation at a time.
`timescale 1ns / 1ps

module deq_ctrl
	import deq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  deq_status_t status,
	output deq_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					in_ready_q <= !(in_valid && in_ready_q);
					if (in_valid && in_ready_q) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (status.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid && in_ready_q;
		cmd.exec    = (state_q == ST_EXEC);
		cmd.read    = (state_q == ST_READ);
		cmd.load    = (state_q == ST_RESP) && status.out_free;
	end

endmodule

FILE: hdl/deq_datapath.sv
// Datapath of the deque: storage, indices, count and the result register.
`timescale 1ns / 1ps

module deq_datapath
	import deq_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  deq_cmd_t                 cmd,
	output deq_status_t              status,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] popped,
	output logic signed [WORD_W-1:0] front_word,
	output logic signed [WORD_W-1:0] back_word,
	output logic [FILL_W-1:0]        fill,
	output logic                     error
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [KIND_W-1:0] kind_q;
	logic [WORD_W-1:0] value_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic              err_q;
	logic [WORD_W-1:0] popped_q;
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic              out_valid_q;

	logic              is_push;
	logic              err;
	logic [CW-1:0]     back_off;
	logic [AW-1:0]     back_slot;
	logic [AW-1:0]     tail_slot;
	logic [AW-1:0]     prev_front;
	logic [AW-1:0]     next_front;
	logic [AW-1:0]     rd_addr_a;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;

	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
	                                          input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	always_comb begin
		is_push    = !kind_q[1];
		err        = is_push ? (count_q == CW'(DEPTH)) : (count_q == '0);
		back_off   = (count_q == '0) ? '0 : count_q - CW'(1);
		back_slot  = slot_at(front_q, back_off);
		tail_slot  = slot_at(front_q, count_q);
		prev_front = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
		next_front = slot_at(front_q, CW'(1));
		rd_addr_a  = (cmd.exec && kind_q == KIND_POP_BACK) ? back_slot : front_q;
		mem_we     = cmd.exec && is_push && !err;
		mem_wa     = (kind_q == KIND_PUSH_FRONT) ? prev_front : tail_slot;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= value_q;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[back_slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			value_q <= value;
		end
		if (cmd.exec) begin
			err_q <= err;
		end
		if (cmd.read) begin
			popped_q <= (!err_q && kind_q[1]) ? rd_a_q : '0;
		end
		if (cmd.load) begin
			popped     <= popped_q;
			front_word <= (count_q == '0) ? '0 : rd_a_q;
			back_word  <= (count_q == '0) ? '0 : rd_b_q;
			fill       <= FILL_W'(count_q);
			error      <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && !err) begin
				case (kind_q)
					KIND_PUSH_FRONT: begin
						front_q <= prev_front;
						count_q <= count_q + CW'(1);
					end
					KIND_PUSH_BACK: begin
						count_q <= count_q + CW'(1);
					end
					KIND_POP_FRONT: begin
						front_q <= next_front;
						count_q <= count_q - CW'(1);
					end
					default: begin
						count_q <= count_q - CW'(1);
					end
				endcase
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

FILE: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
//
//  Channel   Signals                                        Direction
//  input     in_valid, in_ready, kind, value                into block
//  output    out_valid, out_ready, popped, front_word,      out of block
//            back_word, fill, error
//
// Each operation runs through four steps: accept, memory update or pop read,
// a read of the front and back entries on the two memory read ports, and
// the load of the result register. The memory's registered reads set this.
// The result register frees the input side: the next transaction is taken
// while a result still waits, and only its own result load stalls on it.
// Reset clears the indices and the count; storage holds no reset value.
`timescale 1ns / 1ps

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [WORD_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] popped,
	output logic signed [WORD_W-1:0] front_word,
	output logic signed [WORD_W-1:0] back_word,
	output logic [FILL_W-1:0]        fill,
	output logic                     error
);

	deq_cmd_t    cmd;
	deq_status_t status;

	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	deq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.kind       (kind),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.popped     (popped),
		.front_word (front_word),
		.back_word  (back_word),
		.fill       (fill),
		.error      (error)
	);

endmodule
